// File: hw/rtl/et_pkg.sv
// et_pkg: shared types and constants of the expression tokenizer.
// Token record, the batch handed from the lexer to the output queue, token codes.
// No dependencies.
`default_nettype none
package et_pkg;

  localparam logic [12:0] MAX_LENGTH = 13'd4096;
  localparam logic [3:0]  MAX_LEVEL  = 4'd15;
  localparam int          QDEPTH     = 8;
  localparam int          QAW        = $clog2(QDEPTH);

  localparam logic [2:0] K_END  = 3'd0;
  localparam logic [2:0] K_LIT  = 3'd1;
  localparam logic [2:0] K_NAME = 3'd2;
  localparam logic [2:0] K_SYM  = 3'd3;
  localparam logic [2:0] K_TAB  = 3'd4;
  localparam logic [2:0] K_ERR  = 3'd5;

  localparam logic [2:0] L_NONE  = 3'd0;
  localparam logic [2:0] L_NIL   = 3'd1;
  localparam logic [2:0] L_FALSE = 3'd2;
  localparam logic [2:0] L_TRUE  = 3'd3;
  localparam logic [2:0] L_NUM   = 3'd4;
  localparam logic [2:0] L_QSTR  = 3'd5;
  localparam logic [2:0] L_LSTR  = 3'd6;

  localparam logic [1:0] C_NONE = 2'd0;
  localparam logic [1:0] C_BRK  = 2'd1;
  localparam logic [1:0] C_BIN  = 2'd2;
  localparam logic [1:0] C_UN   = 2'd3;

  localparam logic [4:0] OP_NONE   = 5'd0;
  localparam logic [4:0] OP_LP     = 5'd1;
  localparam logic [4:0] OP_RP     = 5'd2;
  localparam logic [4:0] OP_LB     = 5'd3;
  localparam logic [4:0] OP_RB     = 5'd4;
  localparam logic [4:0] OP_DOT    = 5'd5;
  localparam logic [4:0] OP_LC     = 5'd6;
  localparam logic [4:0] OP_RC     = 5'd7;
  localparam logic [4:0] OP_COMMA  = 5'd8;
  localparam logic [4:0] OP_ASSIGN = 5'd9;
  localparam logic [4:0] OP_PLUS   = 5'd10;
  localparam logic [4:0] OP_MINUS  = 5'd11;
  localparam logic [4:0] OP_MUL    = 5'd12;
  localparam logic [4:0] OP_DIV    = 5'd13;
  localparam logic [4:0] OP_POW    = 5'd14;
  localparam logic [4:0] OP_MOD    = 5'd15;
  localparam logic [4:0] OP_LT     = 5'd16;
  localparam logic [4:0] OP_GT     = 5'd17;
  localparam logic [4:0] OP_LE     = 5'd18;
  localparam logic [4:0] OP_GE     = 5'd19;
  localparam logic [4:0] OP_EQ     = 5'd20;
  localparam logic [4:0] OP_NE     = 5'd21;
  localparam logic [4:0] OP_CONCAT = 5'd22;
  localparam logic [4:0] OP_LEN    = 5'd23;
  localparam logic [4:0] OP_AND    = 5'd24;
  localparam logic [4:0] OP_OR     = 5'd25;
  localparam logic [4:0] OP_NOT    = 5'd26;
  localparam logic [4:0] OP_TILDE  = 5'd27;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  lit;
    logic [1:0]  cls;
    logic [4:0]  op;
    logic [11:0] start;
    logic [12:0] len;
    logic        last;
  } token_t;

  typedef struct packed {
    logic             wr;
    logic [1:0]       cnt;
    token_t [2:0]     tok;
  } tok_batch_t;

endpackage
`default_nettype wire

// File: hw/rtl/et_front.sv
// et_front: character lexer; classifies each accepted character and
// produces up to three finished tokens per request. Depends on et_pkg.
`default_nettype none
module et_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fire,
  input  wire logic [7:0]        char_in,
  output et_pkg::tok_batch_t     batch
);

  typedef enum logic [3:0] {
    M_IDLE, M_OP, M_NAME, M_INT, M_FRAC, M_EXPS, M_EXPSIGN, M_EXPD,
    M_SQ, M_DQ, M_SQESC, M_DQESC, M_LOPEN, M_LBODY, M_LCLOSE
  } mode_t;

  mode_t       mode, mode_next;
  logic [12:0] pos, pos_next;
  logic [12:0] tok_begin, tok_begin_next;
  logic [4:0]  held, held_next;
  logic [3:0]  lvl, lvl_next;
  logic [3:0]  cc, cc_next;
  logic [2:0]  nf, nf_next;
  logic [39:0] pre, pre_next;
  logic [2:0]  wl, wl_next;
  logic        skip, skip_next;

  function automatic et_pkg::token_t mk(logic [2:0] k, logic [2:0] l, logic [1:0] s,
                                        logic [4:0] o, logic [12:0] st, logic [12:0] ln);
    et_pkg::token_t t;
    t.kind = k; t.lit = l; t.cls = s; t.op = o;
    t.start = st[11:0]; t.len = ln; t.last = 1'b0;
    return t;
  endfunction

  function automatic logic is_dig(logic [7:0] ch);
    return ch inside {["0":"9"]};
  endfunction

  function automatic logic is_alp(logic [7:0] ch);
    return ch inside {["a":"z"], ["A":"Z"]};
  endfunction

  function automatic logic is_xd(logic [7:0] ch);
    return ch inside {["0":"9"], ["a":"f"], ["A":"F"]};
  endfunction

  always_comb begin
    et_pkg::token_t [2:0] tv;
    logic [1:0]  n;
    logic        do_start;
    logic        err;
    logic        fin;
    logic        hold_op;
    logic        hex, dig, expc;
    logic [7:0]  c;
    logic [7:0]  delim;
    logic [12:0] perr;
    mode_next = mode; pos_next = pos; tok_begin_next = tok_begin; held_next = held;
    lvl_next = lvl; cc_next = cc; nf_next = nf; pre_next = pre; wl_next = wl;
    skip_next = skip;
    tv = '0; n = 2'd0; do_start = 1'b0; err = 1'b0; fin = 1'b0; hold_op = 1'b0;
    c = char_in;
    delim = (mode == M_SQ) ? 8'h27 : 8'h22;
    hex = nf[0];
    dig = hex ? is_xd(c) : is_dig(c);
    expc = hex ? (c == "p" || c == "P") : (c == "e" || c == "E");
    perr = (pos >= et_pkg::MAX_LENGTH) ? (et_pkg::MAX_LENGTH - 13'd1) : pos;
    if (skip) begin
      if (c == 8'd0) begin
        skip_next = 1'b0;
        mode_next = M_IDLE;
        pos_next = '0;
      end
    end else begin
      if (c != 8'd0 && pos >= et_pkg::MAX_LENGTH) begin
        err = 1'b1;
      end else begin
        case (mode)
          M_OP: begin
            mode_next = M_IDLE;
            case (held)
              et_pkg::OP_LT, et_pkg::OP_GT, et_pkg::OP_ASSIGN: begin
                if (c == "=") begin
                  tv[n] = mk(et_pkg::K_SYM, et_pkg::L_NONE, et_pkg::C_BIN,
                             (held == et_pkg::OP_LT) ? et_pkg::OP_LE :
                             (held == et_pkg::OP_GT) ? et_pkg::OP_GE : et_pkg::OP_EQ,
                             tok_begin, 13'd2);
                  n = n + 2'd1;
                end else begin
                  if (held == et_pkg::OP_ASSIGN)
                    tv[n] = mk(et_pkg::K_TAB, et_pkg::L_NONE, et_pkg::C_NONE,
                               et_pkg::OP_ASSIGN, tok_begin, 13'd1);
                  else
                    tv[n] = mk(et_pkg::K_SYM, et_pkg::L_NONE, et_pkg::C_BIN,
                               held, tok_begin, 13'd1);
                  n = n + 2'd1;
                  do_start = 1'b1;
                end
              end
              et_pkg::OP_TILDE: begin
                if (c == "=") begin
                  tv[n] = mk(et_pkg::K_SYM, et_pkg::L_NONE, et_pkg::C_BIN,
                             et_pkg::OP_NE, tok_begin, 13'd2);
                  n = n + 2'd1;
                end else begin
                  err = 1'b1;
                end
              end
              et_pkg::OP_LB: begin
                if (c == "[") begin
                  mode_next = M_LBODY;
                  lvl_next = '0;
                  tok_begin_next = pos + 13'd1;
                end else if (c == "=") begin
                  mode_next = M_LOPEN;
                  lvl_next = 4'd1;
                end else begin
                  tv[n] = mk(et_pkg::K_SYM, et_pkg::L_NONE, et_pkg::C_BRK,
                             et_pkg::OP_LB, tok_begin, 13'd1);
                  n = n + 2'd1;
                  do_start = 1'b1;
                end
              end
              et_pkg::OP_DOT: begin
                if (c == ".") begin
                  mode_next = M_OP;
                  held_next = et_pkg::OP_CONCAT;
                end else if (is_dig(c)) begin
                  mode_next = M_FRAC;
                  nf_next = '0;
                end else begin
                  tv[n] = mk(et_pkg::K_SYM, et_pkg::L_NONE, et_pkg::C_BRK,
                             et_pkg::OP_DOT, tok_begin, 13'd1);
                  n = n + 2'd1;
                  do_start = 1'b1;
                end
              end
              et_pkg::OP_CONCAT: begin
                if (c == ".") begin
                  err = 1'b1;
                end else begin
                  tv[n] = mk(et_pkg::K_SYM, et_pkg::L_NONE, et_pkg::C_BIN,
                             et_pkg::OP_CONCAT, tok_begin, 13'd2);
                  n = n + 2'd1;
                  do_start = 1'b1;
                end
              end
              default: do_start = 1'b1;
            endcase
          end
          M_NAME: begin
            if (c == "_" || is_alp(c) || is_dig(c)) begin
              if (wl < 3'd5) pre_next = {pre[31:0], c};
              if (wl < 3'd6) wl_next = wl + 3'd1;
            end else begin
              if (wl == 3'd3 && pre == 40'h6E696C)
                tv[n] = mk(et_pkg::K_LIT, et_pkg::L_NIL, et_pkg::C_NONE, et_pkg::OP_NONE,
                           tok_begin, pos - tok_begin);
              else if (wl == 3'd5 && pre == 40'h66616C7365)
                tv[n] = mk(et_pkg::K_LIT, et_pkg::L_FALSE, et_pkg::C_NONE,
                           et_pkg::OP_NONE, tok_begin, pos - tok_begin);
              else if (wl == 3'd4 && pre == 40'h74727565)
                tv[n] = mk(et_pkg::K_LIT, et_pkg::L_TRUE, et_pkg::C_NONE,
                           et_pkg::OP_NONE, tok_begin, pos - tok_begin);
              else if (wl == 3'd3 && pre == 40'h616E64)
                tv[n] = mk(et_pkg::K_SYM, et_pkg::L_NONE, et_pkg::C_BIN, et_pkg::OP_AND,
                           tok_begin, pos - tok_begin);
              else if (wl == 3'd2 && pre == 40'h6F72)
                tv[n] = mk(et_pkg::K_SYM, et_pkg::L_NONE, et_pkg::C_BIN, et_pkg::OP_OR,
                           tok_begin, pos - tok_begin);
              else if (wl == 3'd3 && pre == 40'h6E6F74)
                tv[n] = mk(et_pkg::K_SYM, et_pkg::L_NONE, et_pkg::C_UN, et_pkg::OP_NOT,
                           tok_begin, pos - tok_begin);
              else
                tv[n] = mk(et_pkg::K_NAME, et_pkg::L_NONE, et_pkg::C_NONE,
                           et_pkg::OP_NONE, tok_begin, pos - tok_begin);
              n = n + 2'd1;
              do_start = 1'b1;
            end
          end
          M_INT: begin
            if (nf[1] && (c == "x" || c == "X")) begin
              nf_next = 3'b001;
            end else begin
              nf_next = nf & 3'b101;
              if (dig) begin
              end else if (c == ".") mode_next = M_FRAC;
              else if (expc) mode_next = M_EXPS;
              else fin = 1'b1;
            end
          end
          M_FRAC: begin
            if (dig) begin
            end else if (expc) mode_next = M_EXPS;
            else fin = 1'b1;
          end
          M_EXPS: begin
            if (c == "+" || c == "-") begin
              mode_next = M_EXPSIGN;
              nf_next = (c == "-") ? (nf | 3'b100) : (nf & 3'b011);
            end else if (is_dig(c)) mode_next = M_EXPD;
            else fin = 1'b1;
          end
          M_EXPSIGN: begin
            if (is_dig(c)) begin
              mode_next = M_EXPD;
            end else begin
              tv[n] = mk(et_pkg::K_LIT, et_pkg::L_NUM, et_pkg::C_NONE, et_pkg::OP_NONE,
                         tok_begin, pos - 13'd1 - tok_begin);
              n = n + 2'd1;
              tv[n] = mk(et_pkg::K_SYM, et_pkg::L_NONE, et_pkg::C_BIN,
                         nf[2] ? et_pkg::OP_MINUS : et_pkg::OP_PLUS, pos - 13'd1, 13'd1);
              n = n + 2'd1;
              do_start = 1'b1;
            end
          end
          M_EXPD: begin
            if (!is_dig(c)) fin = 1'b1;
          end
          M_SQ, M_DQ: begin
            if (c == 8'd0) err = 1'b1;
            else if (c == delim) begin
              mode_next = M_IDLE;
              tv[n] = mk(et_pkg::K_LIT, et_pkg::L_QSTR, et_pkg::C_NONE, et_pkg::OP_NONE,
                         tok_begin, pos - tok_begin);
              n = n + 2'd1;
            end else if (c == "\\") begin
              mode_next = (mode == M_SQ) ? M_SQESC : M_DQESC;
            end
          end
          M_SQESC, M_DQESC: begin
            if (c == 8'd0) err = 1'b1;
            else mode_next = (mode == M_SQESC) ? M_SQ : M_DQ;
          end
          M_LOPEN: begin
            if (c == "=" && lvl < et_pkg::MAX_LEVEL) lvl_next = lvl + 4'd1;
            else if (c == "[") begin
              mode_next = M_LBODY;
              cc_next = '0;
              tok_begin_next = pos + 13'd1;
            end else err = 1'b1;
          end
          M_LBODY: begin
            if (c == 8'd0) err = 1'b1;
            else if (c == "]") begin
              mode_next = M_LCLOSE;
              cc_next = '0;
            end
          end
          M_LCLOSE: begin
            if (c == 8'd0) err = 1'b1;
            else if (c == "=" && cc < lvl) cc_next = cc + 4'd1;
            else if (c == "]" && cc == lvl) begin
              mode_next = M_IDLE;
              tv[n] = mk(et_pkg::K_LIT, et_pkg::L_LSTR, et_pkg::C_NONE, et_pkg::OP_NONE,
                         tok_begin, pos - {9'd0, lvl} - 13'd1 - tok_begin);
              n = n + 2'd1;
            end else if (c == "]") cc_next = '0;
            else mode_next = M_LBODY;
          end
          default: do_start = 1'b1;
        endcase
      end
      if (fin) begin
        tv[n] = mk(et_pkg::K_LIT, et_pkg::L_NUM, et_pkg::C_NONE, et_pkg::OP_NONE,
                   tok_begin, pos - tok_begin);
        n = n + 2'd1;
        do_start = 1'b1;
      end
      if (do_start) begin
        mode_next = M_IDLE;
        case (c)
          8'd0: begin
            tv[n] = mk(et_pkg::K_END, et_pkg::L_NONE, et_pkg::C_NONE, et_pkg::OP_NONE,
                       13'd0, 13'd0);
            n = n + 2'd1;
          end
          "(", ")", "]", "+", "-", "*", "/", "^", "%", "#": begin
            case (c)
              "(": tv[n] = mk(et_pkg::K_SYM, 3'd0, et_pkg::C_BRK, et_pkg::OP_LP, pos, 13'd1);
              ")": tv[n] = mk(et_pkg::K_SYM, 3'd0, et_pkg::C_BRK, et_pkg::OP_RP, pos, 13'd1);
              "]": tv[n] = mk(et_pkg::K_SYM, 3'd0, et_pkg::C_BRK, et_pkg::OP_RB, pos, 13'd1);
              "+": tv[n] = mk(et_pkg::K_SYM, 3'd0, et_pkg::C_BIN, et_pkg::OP_PLUS, pos, 13'd1);
              "-": tv[n] = mk(et_pkg::K_SYM, 3'd0, et_pkg::C_BIN, et_pkg::OP_MINUS, pos, 13'd1);
              "*": tv[n] = mk(et_pkg::K_SYM, 3'd0, et_pkg::C_BIN, et_pkg::OP_MUL, pos, 13'd1);
              "/": tv[n] = mk(et_pkg::K_SYM, 3'd0, et_pkg::C_BIN, et_pkg::OP_DIV, pos, 13'd1);
              "^": tv[n] = mk(et_pkg::K_SYM, 3'd0, et_pkg::C_BIN, et_pkg::OP_POW, pos, 13'd1);
              "%": tv[n] = mk(et_pkg::K_SYM, 3'd0, et_pkg::C_BIN, et_pkg::OP_MOD, pos, 13'd1);
              default: tv[n] = mk(et_pkg::K_SYM, 3'd0, et_pkg::C_UN, et_pkg::OP_LEN, pos, 13'd1);
            endcase
            n = n + 2'd1;
          end
          "{", "}", ",": begin
            tv[n] = mk(et_pkg::K_TAB, et_pkg::L_NONE, et_pkg::C_NONE,
                       (c == "{") ? et_pkg::OP_LC : (c == "}") ? et_pkg::OP_RC :
                       et_pkg::OP_COMMA, pos, 13'd1);
            n = n + 2'd1;
          end
          "<": begin held_next = et_pkg::OP_LT; hold_op = 1'b1; end
          ">": begin held_next = et_pkg::OP_GT; hold_op = 1'b1; end
          "=": begin held_next = et_pkg::OP_ASSIGN; hold_op = 1'b1; end
          "~": begin held_next = et_pkg::OP_TILDE; hold_op = 1'b1; end
          "[": begin held_next = et_pkg::OP_LB; hold_op = 1'b1; end
          ".": begin held_next = et_pkg::OP_DOT; hold_op = 1'b1; end
          8'h27: begin mode_next = M_SQ; tok_begin_next = pos + 13'd1; end
          8'h22: begin mode_next = M_DQ; tok_begin_next = pos + 13'd1; end
          default: begin
            if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
            end else if (is_dig(c)) begin
              mode_next = M_INT;
              nf_next = (c == "0") ? 3'b010 : 3'b000;
              tok_begin_next = pos;
            end else if (c == "_" || is_alp(c)) begin
              mode_next = M_NAME;
              pre_next = {32'd0, c};
              wl_next = 3'd1;
              tok_begin_next = pos;
            end else begin
              err = 1'b1;
            end
          end
        endcase
        if (hold_op) begin
          mode_next = M_OP;
          tok_begin_next = pos;
        end
      end
      if (err) begin
        mode_next = M_IDLE;
        skip_next = (c != 8'd0);
        tv[n] = mk(et_pkg::K_ERR, et_pkg::L_NONE, et_pkg::C_NONE, et_pkg::OP_NONE,
                   perr, 13'd0);
        n = n + 2'd1;
      end
      if (c == 8'd0) begin
        pos_next = '0;
        mode_next = M_IDLE;
      end else if (pos < et_pkg::MAX_LENGTH) begin
        pos_next = pos + 13'd1;
      end
    end
    if (n != 2'd0) tv[n - 2'd1].last = 1'b1;
    batch.wr = fire;
    batch.cnt = n;
    batch.tok = tv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE; pos <= '0; tok_begin <= '0; held <= '0; lvl <= '0; cc <= '0;
      nf <= '0; pre <= '0; wl <= '0; skip <= 1'b0;
    end else if (fire) begin
      mode <= mode_next; pos <= pos_next; tok_begin <= tok_begin_next; held <= held_next;
      lvl <= lvl_next; cc <= cc_next; nf <= nf_next; pre <= pre_next; wl <= wl_next;
      skip <= skip_next;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/et_queue.sv
// et_queue: token queue between lexer and result port; takes up to three
// tokens per cycle, gives one. Depends on et_pkg.
`default_nettype none
module et_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  et_pkg::tok_batch_t      batch,
  input  wire logic               pop,
  output logic                    full,
  output logic                    empty,
  output et_pkg::token_t          head
);

  et_pkg::token_t mem [et_pkg::QDEPTH];
  logic [et_pkg::QAW-1:0] wptr, rptr;
  logic [et_pkg::QAW:0]   count;
  logic                   rd;
  logic [et_pkg::QAW:0]   wcnt;

  assign empty = (count == '0);
  assign full  = (count > (et_pkg::QAW+1)'(et_pkg::QDEPTH - 3));
  assign head  = mem[rptr];
  assign rd    = pop && !empty;
  assign wcnt  = batch.wr ? (et_pkg::QAW+1)'(batch.cnt) : '0;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (batch.wr && i < int'(batch.cnt))
        mem[wptr + et_pkg::QAW'(i)] <= batch.tok[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      wptr <= wptr + wcnt[et_pkg::QAW-1:0];
      if (rd) rptr <= rptr + 1'b1;
      count <= count + wcnt - (et_pkg::QAW+1)'(rd);
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/expression_tokenizer.sv
// expression_tokenizer: top level; lexer front end feeding a token queue.
// Depends on et_pkg, et_front, et_queue.
//
// Usage: characters enter on char_in; a request is taken when push is high
// and full is low. A zero character ends the expression. Tokens leave in
// order on the result ports while empty is low; pop takes the oldest one.
// Each character yields zero to three tokens; last_of_run marks the final
// token of one character.
// Each token is registered into the queue when the character that ends it is taken.
// Throughput: one character per cycle while full is low; the output drains
// one token per cycle while pop is high, through an eight-entry queue, and
// full rises when fewer than three entries are free.
// Reset (rst, synchronous) clears lexer state and empties the queue.
// When the receiver stalls, tokens wait in the queue and full rises once it
// holds six; characters are then held off until pops free space.
`default_nettype none
module expression_tokenizer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  char_in,
  output logic             empty,
  input  wire logic        pop,
  output logic [2:0]       token_kind,
  output logic [2:0]       literal_kind,
  output logic [1:0]       symbol_class,
  output logic [4:0]       operator_code,
  output logic [11:0]      value_start,
  output logic [12:0]      value_length,
  output logic             last_of_run
);

  et_pkg::tok_batch_t batch;
  et_pkg::token_t     head;
  logic               fire;

  assign fire = push && !full;

  et_front u_front (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .char_in (char_in),
    .batch   (batch)
  );

  et_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .batch (batch),
    .pop   (pop),
    .full  (full),
    .empty (empty),
    .head  (head)
  );

  assign token_kind    = head.kind;
  assign literal_kind  = head.lit;
  assign symbol_class  = head.cls;
  assign operator_code = head.op;
  assign value_start   = head.start;
  assign value_length  = head.len;
  assign last_of_run   = head.last;

endmodule
`default_nettype wire

// File: tb/expression_tokenizer_checker.sv
// expression_tokenizer_checker: watches the character and token channels,
// predicts the tokens of each accepted character and compares them in order.
// Depends on et_pkg.
module expression_tokenizer_checker
  import et_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  char_in,
  input  logic        empty,
  input  logic        pop,
  input  logic [2:0]  token_kind,
  input  logic [2:0]  literal_kind,
  input  logic [1:0]  symbol_class,
  input  logic [4:0]  operator_code,
  input  logic [11:0] value_start,
  input  logic [12:0] value_length,
  input  logic        last_of_run,
  output int          errors,
  output int          pending
);

  typedef enum logic [4:0] {
    S_IDLE, S_OP, S_NAME, S_INT, S_FRAC, S_EXPS, S_EXPSIGN, S_EXPD,
    S_SQ, S_DQ, S_SQESC, S_DQESC, S_LOPEN, S_LBODY, S_LCLOSE
  } lex_mode_t;

  lex_mode_t   mode;
  logic [12:0] pos;
  logic [12:0] tok_begin;
  logic [4:0]  held;
  logic [3:0]  level;
  logic [3:0]  closes;
  logic        f_hex, f_lz, f_neg;
  logic [39:0] prefix;
  logic [2:0]  wlen;
  logic        drop;
  token_t      tokens_due[$];
  token_t      batch[$];

  assign pending = tokens_due.size();

  function automatic bit is_dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic bit is_alp(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction
  function automatic bit is_hex(logic [7:0] c);
    return is_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  task automatic put(logic [2:0] k, logic [2:0] l, logic [1:0] cl, logic [4:0] o,
                     logic [12:0] s, logic [12:0] n);
    token_t t;
    t.kind = k; t.lit = l; t.cls = cl; t.op = o; t.start = s[11:0]; t.len = n;
    t.last = 0;
    if (batch.size() < 3) batch.push_back(t);
  endtask

  task automatic fail_at(logic [7:0] c, logic [12:0] p);
    mode = S_IDLE;
    drop = (c != 0);
    put(K_ERR, L_NONE, C_NONE, OP_NONE, (p < MAX_LENGTH) ? p : MAX_LENGTH - 1, 0);
  endtask

  task automatic begin_token(logic [7:0] c, logic [12:0] p);
    mode = S_IDLE;
    case (c)
      8'd0: begin put(K_END, L_NONE, C_NONE, OP_NONE, 0, 0); return; end
      "(": begin put(K_SYM, L_NONE, C_BRK, OP_LP, p, 1); return; end
      ")": begin put(K_SYM, L_NONE, C_BRK, OP_RP, p, 1); return; end
      "]": begin put(K_SYM, L_NONE, C_BRK, OP_RB, p, 1); return; end
      "{": begin put(K_TAB, L_NONE, C_NONE, OP_LC, p, 1); return; end
      "}": begin put(K_TAB, L_NONE, C_NONE, OP_RC, p, 1); return; end
      ",": begin put(K_TAB, L_NONE, C_NONE, OP_COMMA, p, 1); return; end
      "+": begin put(K_SYM, L_NONE, C_BIN, OP_PLUS, p, 1); return; end
      "-": begin put(K_SYM, L_NONE, C_BIN, OP_MINUS, p, 1); return; end
      "*": begin put(K_SYM, L_NONE, C_BIN, OP_MUL, p, 1); return; end
      "/": begin put(K_SYM, L_NONE, C_BIN, OP_DIV, p, 1); return; end
      "^": begin put(K_SYM, L_NONE, C_BIN, OP_POW, p, 1); return; end
      "%": begin put(K_SYM, L_NONE, C_BIN, OP_MOD, p, 1); return; end
      "#": begin put(K_SYM, L_NONE, C_UN, OP_LEN, p, 1); return; end
      "<": held = OP_LT;
      ">": held = OP_GT;
      "=": held = OP_ASSIGN;
      "~": held = OP_TILDE;
      "[": held = OP_LB;
      ".": held = OP_DOT;
      "'": begin mode = S_SQ; tok_begin = p + 1; return; end
      "\"": begin mode = S_DQ; tok_begin = p + 1; return; end
      default: begin
        if (c == " " || (c >= 9 && c <= 13)) return;
        if (is_dig(c)) begin
          mode = S_INT; f_hex = 0; f_lz = (c == "0"); f_neg = 0; tok_begin = p;
          return;
        end
        if (c == "_" || is_alp(c)) begin
          mode = S_NAME; prefix = {32'd0, c}; wlen = 1; tok_begin = p;
          return;
        end
        fail_at(c, p);
        return;
      end
    endcase
    mode = S_OP;
    tok_begin = p;
  endtask

  task automatic close_name(logic [12:0] p);
    logic [12:0] n;
    n = p - tok_begin;
    mode = S_IDLE;
    if (wlen == 3 && prefix == 40'h6E696C) put(K_LIT, L_NIL, C_NONE, OP_NONE, tok_begin, n);
    else if (wlen == 5 && prefix == 40'h66616C7365)
      put(K_LIT, L_FALSE, C_NONE, OP_NONE, tok_begin, n);
    else if (wlen == 4 && prefix == 40'h74727565)
      put(K_LIT, L_TRUE, C_NONE, OP_NONE, tok_begin, n);
    else if (wlen == 3 && prefix == 40'h616E64) put(K_SYM, L_NONE, C_BIN, OP_AND, tok_begin, n);
    else if (wlen == 2 && prefix == 40'h6F72) put(K_SYM, L_NONE, C_BIN, OP_OR, tok_begin, n);
    else if (wlen == 3 && prefix == 40'h6E6F74) put(K_SYM, L_NONE, C_UN, OP_NOT, tok_begin, n);
    else put(K_NAME, L_NONE, C_NONE, OP_NONE, tok_begin, n);
  endtask

  task automatic close_number(logic [12:0] e);
    mode = S_IDLE;
    put(K_LIT, L_NUM, C_NONE, OP_NONE, tok_begin, e - tok_begin);
  endtask

  task automatic after_held(logic [7:0] c, logic [12:0] p);
    logic [12:0] s;
    s = tok_begin;
    mode = S_IDLE;
    case (held)
      OP_LT: begin
        if (c == "=") begin put(K_SYM, L_NONE, C_BIN, OP_LE, s, 2); return; end
        put(K_SYM, L_NONE, C_BIN, OP_LT, s, 1);
      end
      OP_GT: begin
        if (c == "=") begin put(K_SYM, L_NONE, C_BIN, OP_GE, s, 2); return; end
        put(K_SYM, L_NONE, C_BIN, OP_GT, s, 1);
      end
      OP_ASSIGN: begin
        if (c == "=") begin put(K_SYM, L_NONE, C_BIN, OP_EQ, s, 2); return; end
        put(K_TAB, L_NONE, C_NONE, OP_ASSIGN, s, 1);
      end
      OP_TILDE: begin
        if (c == "=") put(K_SYM, L_NONE, C_BIN, OP_NE, s, 2);
        else fail_at(c, p);
        return;
      end
      OP_LB: begin
        if (c == "[") begin mode = S_LBODY; level = 0; tok_begin = p + 1; return; end
        if (c == "=") begin mode = S_LOPEN; level = 1; return; end
        put(K_SYM, L_NONE, C_BRK, OP_LB, s, 1);
      end
      OP_DOT: begin
        if (c == ".") begin mode = S_OP; held = OP_CONCAT; return; end
        if (is_dig(c)) begin mode = S_FRAC; f_hex = 0; f_lz = 0; f_neg = 0; return; end
        put(K_SYM, L_NONE, C_BRK, OP_DOT, s, 1);
      end
      OP_CONCAT: begin
        if (c == ".") begin fail_at(c, p); return; end
        put(K_SYM, L_NONE, C_BIN, OP_CONCAT, s, 2);
      end
      default: ;
    endcase
    begin_token(c, p);
  endtask

  task automatic in_number(logic [7:0] c, logic [12:0] p);
    bit dg, ex;
    dg = f_hex ? is_hex(c) : is_dig(c);
    ex = f_hex ? (c == "p" || c == "P") : (c == "e" || c == "E");
    case (mode)
      S_INT: begin
        if (f_lz && (c == "x" || c == "X")) begin f_hex = 1; f_lz = 0; f_neg = 0; return; end
        f_lz = 0;
        if (dg) return;
        if (c == ".") begin mode = S_FRAC; return; end
        if (ex) begin mode = S_EXPS; return; end
      end
      S_FRAC: begin
        if (dg) return;
        if (ex) begin mode = S_EXPS; return; end
      end
      S_EXPS: begin
        if (c == "+" || c == "-") begin mode = S_EXPSIGN; f_neg = (c == "-"); return; end
        if (is_dig(c)) begin mode = S_EXPD; return; end
      end
      S_EXPSIGN: begin
        if (is_dig(c)) begin mode = S_EXPD; return; end
        close_number(p - 1);
        put(K_SYM, L_NONE, C_BIN, f_neg ? OP_MINUS : OP_PLUS, p - 1, 1);
        begin_token(c, p);
        return;
      end
      default: if (is_dig(c)) return;
    endcase
    close_number(p);
    begin_token(c, p);
  endtask

  task automatic lex_char(logic [7:0] c);
    logic [12:0] p;
    p = pos;
    batch.delete();
    if (drop) begin
      if (c == 0) begin drop = 0; mode = S_IDLE; pos = 0; end
      return;
    end
    if (c != 0 && p >= MAX_LENGTH) fail_at(c, p);
    else case (mode)
      S_OP: after_held(c, p);
      S_NAME:
        if (c == "_" || is_alp(c) || is_dig(c)) begin
          if (wlen < 5) prefix = {prefix[31:0], c};
          if (wlen < 6) wlen++;
        end else begin
          close_name(p);
          begin_token(c, p);
        end
      S_INT, S_FRAC, S_EXPS, S_EXPSIGN, S_EXPD: in_number(c, p);
      S_SQ, S_DQ:
        if (c == 0) fail_at(c, p);
        else if (c == ((mode == S_SQ) ? "'" : "\"")) begin
          mode = S_IDLE;
          put(K_LIT, L_QSTR, C_NONE, OP_NONE, tok_begin, p - tok_begin);
        end else if (c == "\\") mode = (mode == S_SQ) ? S_SQESC : S_DQESC;
      S_SQESC, S_DQESC:
        if (c == 0) fail_at(c, p);
        else mode = (mode == S_SQESC) ? S_SQ : S_DQ;
      S_LOPEN:
        if (c == "=" && level < MAX_LEVEL) level++;
        else if (c == "[") begin mode = S_LBODY; closes = 0; tok_begin = p + 1; end
        else fail_at(c, p);
      S_LBODY:
        if (c == 0) fail_at(c, p);
        else if (c == "]") begin mode = S_LCLOSE; closes = 0; end
      S_LCLOSE:
        if (c == 0) fail_at(c, p);
        else if (c == "=" && closes < level) closes++;
        else if (c == "]" && closes == level) begin
          mode = S_IDLE;
          put(K_LIT, L_LSTR, C_NONE, OP_NONE, tok_begin, p - level - 1 - tok_begin);
        end else if (c == "]") closes = 0;
        else mode = S_LBODY;
      default: begin_token(c, p);
    endcase
    if (c == 0) begin pos = 0; mode = S_IDLE; end
    else if (p < MAX_LENGTH) pos = p + 1;
    if (batch.size() > 0) batch[batch.size() - 1].last = 1;
    foreach (batch[i]) tokens_due.push_back(batch[i]);
  endtask

  always @(posedge clk) begin
    token_t got, want;
    if (rst) begin
      mode = S_IDLE; pos = 0; tok_begin = 0; held = 0; level = 0; closes = 0;
      f_hex = 0; f_lz = 0; f_neg = 0; prefix = 0; wlen = 0; drop = 0;
      tokens_due.delete();
      errors <= 0;
    end else begin
      if (pop && !empty) begin
        got = '{token_kind, literal_kind, symbol_class, operator_code,
                value_start, value_length, last_of_run};
        if (tokens_due.size() == 0) begin
          if (errors < 10) $display("unexpected token %p", got);
          errors <= errors + 1;
        end else begin
          want = tokens_due.pop_front();
          if (got !== want) begin
            if (errors < 10) $display("token mismatch: expected %p got %p", want, got);
            errors <= errors + 1;
          end
        end
      end
      if (push && !full) lex_char(char_in);
    end
  end

endmodule

// File: tb/expression_tokenizer_test.sv
// expression_tokenizer_test: drives characters into the tokenizer with random
// bursts and stalls; verdict from expression_tokenizer_checker.
// Depends on et_pkg, expression_tokenizer, expression_tokenizer_checker.
module expression_tokenizer_test;
  import et_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        push = 0;
  logic        pop = 0;
  logic [7:0]  char_in = 0;
  logic        full, empty, last_of_run;
  logic [2:0]  token_kind, literal_kind;
  logic [1:0]  symbol_class;
  logic [4:0]  operator_code;
  logic [11:0] value_start;
  logic [12:0] value_length;
  int          errors, pending;
  int          cycles = 0;
  int          budget = 0;
  logic [7:0]  text[$];

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  expression_tokenizer uut (.*);
  expression_tokenizer_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("expression_tokenizer regression: fail");
      $finish;
    end
  end

  // receiver stalls at random, independent of the sender, outside a window of steady pops
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (rst) pop <= 0;
    else if (cycles % 512 < 128) pop <= 1;
    else pop <= (r < 65);
  end

  task automatic send_char(logic [7:0] c);
    if (budget == 0) begin
      int g;
      push <= 0;
      g = (cycles % 700 < 150) ? 0 : $urandom_range(0, 4);
      repeat (g) @(posedge clk);
      budget = $urandom_range(1, 12);
    end
    push <= 1;
    char_in <= c;
    @(posedge clk);
    while (full) @(posedge clk);
    budget--;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  function automatic string pick_piece();
    string pieces[] = '{"abc", "nil", "false", "true", "and", "or", "not", "x_9",
      "0x1fP-3", "12.5e+7", "3e-", "1E+x", ".5", "0xA.b", "'a\\'b'", "\"q\\\"\"",
      "[[lng]]", "[==[a]=]]==]", "<=", ">=", "==", "~=", "..", "<", ">", "=",
      "[", "]", "(", ")", "{", "}", ",", "+", "-", "*", "/", "^", "%", "#",
      ".", " ", "\t", "falsey", "andy", "nile"};
    return pieces[$urandom_range(0, pieces.size() - 1)];
  endfunction

  initial begin
    int sent;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed
    send_text("nil false true and or not x1 _a");
    send_char(8'd0);
    send_text("0x1fp+2 1e-x 3.e+ .25 1..2");
    send_char(8'd0);
    send_text("[==[a]=]b]==] 'x\\'y' \"z\"");
    send_char(8'd0);
    send_text("a~b"); send_char(8'd0);
    send_text("1...2"); send_char(8'd0);
    send_text("[=x"); send_char(8'd0);
    send_text("[================["); send_char(8'd0);
    send_text("'abc"); send_char(8'd0);
    send_text("'\\"); send_char(8'd0);
    send_text("[[ab]"); send_char(8'd0);
    send_text("@ $ "); send_char(8'd255); send_char(8'd128); send_char(8'd0);
    // pause until drained
    push <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // random expressions
    sent = 0;
    while (sent < 24) begin
      int k;
      k = $urandom_range(0, 9);
      if (k == 0) begin
        send_char(8'($urandom_range(0, 255)));
        sent++;
      end else begin
        string s;
        s = pick_piece();
        send_text(s);
        sent += s.len();
        if (k == 1) begin send_char(8'd0); sent++; end
      end
    end
    send_char(8'd0);
    push <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("expression_tokenizer regression: pass");
    else $display("expression_tokenizer regression: fail");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/et_pkg.sv
hw/rtl/et_front.sv
hw/rtl/et_queue.sv
hw/rtl/expression_tokenizer.sv
tb/expression_tokenizer_checker.sv
tb/expression_tokenizer_test.sv
